### sv/i2cm_pkg.sv
// shared types and codes for the i2c master bit sequencer
// command codes, control register codes, phase codes, sequencer state record and result record
// no dependencies
package i2cm_pkg;

   // command codes carried in the request tuser field
   localparam logic [2:0] CMD_TICK    = 3'd0;
   localparam logic [2:0] CMD_RELEASE = 3'd1;
   localparam logic [2:0] CMD_START   = 3'd2;
   localparam logic [2:0] CMD_STOP    = 3'd3;
   localparam logic [2:0] CMD_WRITE   = 3'd4;
   localparam logic [2:0] CMD_READ    = 3'd5;
   localparam logic [2:0] CMD_ACK     = 3'd6;
   localparam logic [2:0] CMD_NACK    = 3'd7;

   // control register indexes and reset values
   localparam logic CSR_HALF_PERIOD = 1'b0;
   localparam logic CSR_POLL_LIMIT  = 1'b1;
   localparam logic [15:0] HALF_PERIOD_RESET = 16'd200;
   localparam logic [15:0] POLL_LIMIT_RESET  = 16'd2000;

   // phase codes used by the sequences
   localparam logic [2:0] PH_0 = 3'd0;
   localparam logic [2:0] PH_1 = 3'd1;
   localparam logic [2:0] PH_2 = 3'd2;
   localparam logic [2:0] PH_3 = 3'd3;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // sequencer state
   typedef struct packed {
      logic        scl;
      logic        sda;
      logic [2:0]  active_cmd;
      logic [2:0]  phase;
      logic [3:0]  bit_count;
      logic [15:0] delay;
      logic [15:0] poll;
      logic [7:0]  shift;
   } i2cm_state_type;

   // one result item
   typedef struct packed {
      logic       rejected;
      logic       ack_timeout;
      logic       ack_seen;
      logic       read_done;
      logic [7:0] read_data;
      logic       busy_res;
      logic       sda_out;
      logic       scl_out;
   } i2cm_result_type;

endpackage

### sv/i2cm_step.sv
// next-state and result logic for one transfer of the i2c master bit sequencer
// purely combinational; the top level registers state and result
// depends on i2cm_pkg
module i2cm_step (
   input  i2cm_pkg::i2cm_state_type  cur_state,
   input  logic [2:0]                cmd,
   input  logic [7:0]                data_byte,
   input  logic                      sda_in,
   input  logic [15:0]               half_period,
   input  logic [15:0]               poll_limit,
   output i2cm_pkg::i2cm_state_type  nxt_state,
   output i2cm_pkg::i2cm_result_type result
);
   import i2cm_pkg::*;

   logic [15:0] hold_ticks;
   logic [2:0]  next_phase;
   logic [3:0]  next_bits;

   // zero half period behaves as one
   assign hold_ticks = (half_period == 16'd0) ? 16'd1 : half_period;
   assign next_phase = cur_state.phase + 3'd1;
   assign next_bits  = cur_state.bit_count + 4'd1;

   always_comb begin
      nxt_state = cur_state;
      result    = '0;

      if (cmd == CMD_TICK) begin
         if (cur_state.active_cmd != CMD_TICK) begin
            if (cur_state.active_cmd == CMD_ACK && cur_state.phase == PH_1) begin
               // polling sda during the acknowledge clock
               if (!sda_in) begin
                  result.ack_seen = 1'b1;
                  nxt_state.scl   = 1'b0;
                  nxt_state.phase = PH_2;
                  nxt_state.delay = hold_ticks;
               end else if (cur_state.poll >= poll_limit) begin
                  result.ack_timeout = 1'b1;
                  nxt_state.scl      = 1'b0;
                  nxt_state.phase    = PH_2;
                  nxt_state.delay    = hold_ticks;
               end else begin
                  nxt_state.poll = cur_state.poll + 16'd1;
               end
            end else if (cur_state.delay > 16'd1) begin
               nxt_state.delay = cur_state.delay - 16'd1;
            end else begin
               // hold over: step the active sequence
               nxt_state.delay = 16'd0;
               unique case (cur_state.active_cmd)
                  CMD_START, CMD_STOP, CMD_NACK: begin
                     if (next_phase >= PH_3) begin
                        nxt_state.active_cmd = CMD_TICK;
                        nxt_state.phase      = PH_0;
                     end else begin
                        nxt_state.phase = next_phase;
                        nxt_state.delay = hold_ticks;
                        if (next_phase == PH_1) begin
                           nxt_state.scl = 1'b1;
                        end else if (cur_state.active_cmd == CMD_START) begin
                           nxt_state.sda = 1'b0;
                        end else if (cur_state.active_cmd == CMD_STOP) begin
                           nxt_state.sda = 1'b1;
                        end else begin
                           nxt_state.scl = 1'b0;
                        end
                     end
                  end
                  CMD_WRITE: begin
                     if (cur_state.phase == PH_0) begin
                        nxt_state.scl   = 1'b1;
                        nxt_state.phase = PH_1;
                        nxt_state.delay = hold_ticks;
                     end else if (cur_state.phase == PH_1) begin
                        nxt_state.scl   = 1'b0;
                        nxt_state.phase = PH_2;
                        nxt_state.delay = hold_ticks;
                     end else if (cur_state.phase == PH_2) begin
                        nxt_state.bit_count = next_bits;
                        if (next_bits < BITS_PER_BYTE) begin
                           // next data bit on sda while scl is low
                           nxt_state.scl   = 1'b0;
                           nxt_state.sda   = cur_state.shift[7];
                           nxt_state.shift = {cur_state.shift[6:0], 1'b0};
                           nxt_state.phase = PH_0;
                        end else begin
                           nxt_state.scl   = 1'b1;
                           nxt_state.phase = PH_3;
                        end
                        nxt_state.delay = hold_ticks;
                     end else begin
                        nxt_state.active_cmd = CMD_TICK;
                        nxt_state.phase      = PH_0;
                     end
                  end
                  CMD_READ: begin
                     if (cur_state.phase == PH_0) begin
                        nxt_state.sda   = 1'b1;
                        nxt_state.phase = PH_1;
                        nxt_state.delay = hold_ticks;
                     end else if (cur_state.phase == PH_1) begin
                        nxt_state.scl   = 1'b1;
                        nxt_state.phase = PH_2;
                        nxt_state.delay = hold_ticks;
                     end else if (cur_state.phase == PH_2) begin
                        // sample sda at the end of scl high
                        nxt_state.shift = {cur_state.shift[6:0], sda_in};
                        nxt_state.scl   = 1'b0;
                        nxt_state.phase = PH_3;
                        nxt_state.delay = hold_ticks;
                     end else begin
                        nxt_state.bit_count = next_bits;
                        if (next_bits < BITS_PER_BYTE) begin
                           nxt_state.scl   = 1'b1;
                           nxt_state.phase = PH_2;
                           nxt_state.delay = hold_ticks;
                        end else begin
                           result.read_done     = 1'b1;
                           result.read_data     = cur_state.shift;
                           nxt_state.active_cmd = CMD_TICK;
                           nxt_state.phase      = PH_0;
                        end
                     end
                  end
                  CMD_ACK: begin
                     if (cur_state.phase == PH_0) begin
                        // first poll on the tick ending the scl high hold
                        if (!sda_in) begin
                           result.ack_seen = 1'b1;
                           nxt_state.scl   = 1'b0;
                           nxt_state.phase = PH_2;
                           nxt_state.delay = hold_ticks;
                        end else if (cur_state.poll >= poll_limit) begin
                           result.ack_timeout = 1'b1;
                           nxt_state.scl      = 1'b0;
                           nxt_state.phase    = PH_2;
                           nxt_state.delay    = hold_ticks;
                        end else begin
                           nxt_state.poll  = cur_state.poll + 16'd1;
                           nxt_state.phase = PH_1;
                        end
                     end else begin
                        nxt_state.active_cmd = CMD_TICK;
                        nxt_state.phase      = PH_0;
                     end
                  end
                  default: begin
                     nxt_state.active_cmd = CMD_TICK;
                     nxt_state.phase      = PH_0;
                  end
               endcase
            end
         end
      end else if (cur_state.active_cmd != CMD_TICK) begin
         result.rejected = 1'b1;
      end else if (cmd == CMD_RELEASE) begin
         nxt_state.scl = 1'b1;
         nxt_state.sda = 1'b1;
      end else begin
         // launch a new sequence
         nxt_state.active_cmd = cmd;
         nxt_state.phase      = PH_0;
         nxt_state.bit_count  = 4'd0;
         nxt_state.poll       = 16'd0;
         nxt_state.delay      = hold_ticks;
         unique case (cmd)
            CMD_WRITE: begin
               nxt_state.scl   = 1'b0;
               nxt_state.sda   = data_byte[7];
               nxt_state.shift = {data_byte[6:0], 1'b0};
            end
            CMD_READ: begin
               nxt_state.shift = 8'd0;
               nxt_state.scl   = 1'b0;
            end
            CMD_ACK: begin
               nxt_state.scl = 1'b1;
            end
            CMD_STOP: begin
               nxt_state.sda = 1'b0;
            end
            default: begin
               // start and nack both release sda first
               nxt_state.sda = 1'b1;
            end
         endcase
      end

      result.scl_out  = nxt_state.scl;
      result.sda_out  = nxt_state.sda;
      result.busy_res = (nxt_state.active_cmd != CMD_TICK);
   end

endmodule

### sv/i2c_master_bit_sequencer_unit.sv
// top level of the i2c master bit sequencer: handshakes, state and result registers
// depends on i2cm_pkg and i2cm_step
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  tuser: cmd; tdata: data_byte, sda_in
//   rsp_     out  rsp_tvalid/rsp_tready  tdata: pin drives, busy, read and ack flags
//   csr_     in   csr_valid/csr_ready    csr_index, csr_data
//
// every request transfer yields one registered response, valid in the next cycle; a new request is
// taken each cycle while the response register is empty or being drained
// the state update is a single pass through i2cm_step into the state registers
// reset restores released lines, idle sequencer and default control registers
// a stalled response holds req_tready low; csr_ready is always high
module i2c_master_bit_sequencer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [8] sda_in, [15:9] zero
   input  logic [2:0]  req_tuser,   // [2:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] scl_out, [1] sda_out, [2] busy_res,
                                    // [10:3] read_data, [11] read_done,
                                    // [12] ack_seen, [13] ack_timeout,
                                    // [14] rejected, [15] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import i2cm_pkg::*;

   i2cm_state_type  state_ff, state_in;
   i2cm_result_type result_ff, result_in;
   logic            rsp_valid_ff;
   logic [15:0]     half_period_ff;
   logic [15:0]     poll_limit_ff;
   logic            req_xfer;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff};

   i2cm_step u_step (
      .cur_state   (state_ff),
      .cmd         (req_tuser),
      .data_byte   (req_tdata[7:0]),
      .sda_in      (req_tdata[8]),
      .half_period (half_period_ff),
      .poll_limit  (poll_limit_ff),
      .nxt_state   (state_in),
      .result      (result_in)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         poll_limit_ff  <= POLL_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_HALF_PERIOD) begin
            half_period_ff <= csr_data;
         end
         if (csr_index == CSR_POLL_LIMIT) begin
            poll_limit_ff <= csr_data;
         end
      end
   end

   // sequencer state, advanced once per request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{scl: 1'b1, sda: 1'b1, active_cmd: CMD_TICK, phase: PH_0,
                       bit_count: 4'd0, delay: 16'd0, poll: 16'd0, shift: 8'd0};
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         result_ff <= result_in;
      end
   end

   // every request transfer produces a response next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_tvalid)
      else $error("response missing after request transfer");

   // idle sequencer never keeps a pending hold
   a_idle_no_delay: assert property (@(posedge clock) disable iff (reset)
      state_ff.active_cmd == CMD_TICK |-> state_ff.delay == 16'd0)
      else $error("hold counter running while idle");

   // a command arriving while busy is flagged and leaves the sequence running
   a_reject: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tuser != CMD_TICK && state_ff.active_cmd != CMD_TICK
      |=> rsp_tdata[14] && state_ff.active_cmd == $past(state_ff.active_cmd))
      else $error("busy command not rejected");

   // bit counter never passes one byte
   a_bit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff.bit_count <= BITS_PER_BYTE)
      else $error("bit counter overran");

endmodule
